/* design/fpba_pkg.sv */
// Package: shared codes and control types for the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

  // Operation codes carried in the input word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Status codes carried in the result word.
  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // Policy codes; the unused code behaves as first fit.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Decoded policy broadcast to every cell.
  typedef struct packed {
    logic best;
    logic worst;
  } fit_ctl_t;

  // Control part of the search token that walks along the cell row.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

`default_nettype wire

/* design/fpba_if.sv */
// Interfaces: the request and response handshake channels of the allocator.
`default_nettype none

interface fpba_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  block_index;
  logic [15:0] size_value;

  modport source (output valid, operation, block_index, size_value, input ready);
  modport sink   (input valid, operation, block_index, size_value, output ready);
endinterface

interface fpba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_block;
  logic [15:0] size_left;

  modport source (output valid, status, chosen_block, size_left, input ready);
  modport sink   (input valid, status, chosen_block, size_left, output ready);
endinterface

`default_nettype wire

/* design/fit_policy_block_allocator.sv */
// Top level: fit-policy block allocator built as a row of search cells.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+----------------------------------------
//   req      | in  | valid/ready   | operation, block_index, size_value
//   rsp      | out | valid/ready   | status, chosen_block, size_left
//   cfg      | in  | cfg_we only   | cfg_index, cfg_data (fit_policy, count)
//
// A load word goes straight from acceptance to the done state; an allocate word
// first passes the search token along the row, one cell per cycle.
// One word is in work at a time; a new word is accepted while a result still
// waits in the output register. Reset clears every block to zero, sets first
// fit and a block count of 16. A stalled output holds the finished word back.
`default_nettype none

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  fpba_req_if.sink        req,
  fpba_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [1:0]           fit_policy;
  logic [4:0]           block_count;
  fit_ctl_t             fit_ctl;

  logic                 op;
  logic [3:0]           op_index;
  logic [SIZE_BITS-1:0] op_size;
  logic                 start;

  logic                 res_found;
  logic [IDX_W-1:0]     res_pick;
  logic [SIZE_BITS-1:0] res_size;
  logic [SIZE_BITS-1:0] size_rem;

  logic                 slot_free;
  logic                 finish;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  logic                 rsp_valid;
  logic [1:0]           rsp_status;
  logic [3:0]           rsp_block;
  logic [15:0]          rsp_size;

  tok_ctl_t             tok      [NUM_BLOCKS+1];
  logic [IDX_W-1:0]     tok_pick [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] tok_size [NUM_BLOCKS+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= FIT_FIRST;
      block_count <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:  fit_policy  <= cfg_data[1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fit_ctl.best  = (fit_policy == FIT_BEST);
  assign fit_ctl.worst = (fit_policy == FIT_WORST);

  // Token entering the first cell: no candidate yet.
  assign tok[0].valid = start;
  assign tok[0].found = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_size[0]  = '0;

  // The row of cells, each holding one block.
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .INDEX     (i),
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (fit_ctl),
      .block_count (block_count),
      .req_size    (op_size),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .tok_in      (tok[i]),
      .pick_in     (tok_pick[i]),
      .size_in     (tok_size[i]),
      .tok_out     (tok[i+1]),
      .pick_out    (tok_pick[i+1]),
      .size_out    (tok_size[i+1])
    );
  end

  assign req.ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;
  assign finish    = (state == S_DONE) && slot_free;
  assign size_rem  = res_size - op_size;

  // Sequencer: accept, search the row for an allocate, then deliver and write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.operation == OP_ALLOC) begin
              start <= 1'b1;
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (tok[NUM_BLOCKS].valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the accepted word and the search outcome.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= req.operation;
      op_index <= req.block_index;
      op_size  <= SIZE_BITS'(req.size_value);
    end
    if (tok[NUM_BLOCKS].valid) begin
      res_found <= tok[NUM_BLOCKS].found;
      res_pick  <= tok_pick[NUM_BLOCKS];
      res_size  <= tok_size[NUM_BLOCKS];
    end
  end

  // Table write: a load inside the table, or the granted block's new size.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = res_pick;
    wr_data = size_rem;
    if (finish) begin
      if (op == OP_LOAD) begin
        wr_en   = 32'(op_index) < NUM_BLOCKS;
        wr_idx  = IDX_W'(op_index);
        wr_data = op_size;
      end else begin
        wr_en   = res_found;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (op == OP_LOAD) begin
        rsp_status <= ST_LOADED;
        rsp_block  <= '0;
        rsp_size   <= '0;
      end else if (res_found) begin
        rsp_status <= ST_ALLOCATED;
        rsp_block  <= 4'(res_pick);
        rsp_size   <= 16'(size_rem);
      end else begin
        rsp_status <= ST_NOT_ALLOC;
        rsp_block  <= '0;
        rsp_size   <= '0;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.chosen_block = rsp_block;
  assign rsp.size_left    = rsp_size;

endmodule

`default_nettype wire

/* design/fpba_cell.sv */
// Cell: holds one block's free size and updates the search token passing through.
`default_nettype none

module fpba_cell
  import fpba_pkg::*;
#(
  parameter int INDEX     = 0,
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fit_ctl_t             ctl,
  input  wire logic [4:0]           block_count,
  input  wire logic [SIZE_BITS-1:0] req_size,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  input  wire tok_ctl_t             tok_in,
  input  wire logic [IDX_W-1:0]     pick_in,
  input  wire logic [SIZE_BITS-1:0] size_in,
  output tok_ctl_t                  tok_out,
  output logic [IDX_W-1:0]          pick_out,
  output logic [SIZE_BITS-1:0]      size_out
);

  logic [SIZE_BITS-1:0] entry;
  logic                 member;
  logic                 take;

  // The block's free size; cleared at reset, written by loads and grants.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
      entry <= wr_data;
    end
  end

  // Only blocks below the configured count take part in the search.
  assign member = 32'(block_count) > INDEX;

  // Decide whether this block replaces the candidate carried by the token.
  always_comb begin
    take = 1'b0;
    if (tok_in.valid && member && (entry >= req_size)) begin
      if (!tok_in.found) begin
        take = 1'b1;
      end else if (ctl.best && (entry < size_in)) begin
        take = 1'b1;
      end else if (ctl.worst && (entry > size_in)) begin
        take = 1'b1;
      end
    end
  end

  // Hand the token on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | take;
    end
  end

  always_ff @(posedge clk) begin
    pick_out <= take ? IDX_W'(INDEX) : pick_in;
    size_out <= take ? entry : size_in;
  end

endmodule

`default_nettype wire

/* test/fpba_grant_checker.sv */
// Checker: watches the allocator's channels, predicts each result word and compares.
module fpba_grant_checker
  import fpba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fpba_req_if        req,
  fpba_rsp_if        rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         open_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_block;
    logic [15:0] size_left;
  } grant_word_t;

  // Own copy of the free-size table and of the two registers.
  logic [15:0] blk_free [TABLE_DEPTH];
  logic [1:0]  fit_mode;
  logic [4:0]  blk_count;
  grant_word_t awaited_grants [$];

  initial begin
    fail_count = 0;
    open_words = 0;
  end

  // Works out the result of one input word and updates the table as the block would.
  function automatic grant_word_t next_grant(logic op, logic [3:0] idx, logic [15:0] want_size);
    grant_word_t res;
    int span;
    int pick;
    bit found;
    res = '0;
    res.status = ST_LOADED;
    if (op == OP_LOAD) begin
      blk_free[idx] = want_size;
      return res;
    end
    span = (blk_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(blk_count);
    found = 1'b0;
    pick = 0;
    for (int j = 0; j < span; j++) begin
      if (blk_free[j] >= want_size) begin
        if (!found) begin
          found = 1'b1;
          pick = j;
          // First fit, and the unused code with it, stops at the first candidate.
          if (fit_mode != FIT_BEST && fit_mode != FIT_WORST) break;
        end else if (fit_mode == FIT_BEST && blk_free[j] < blk_free[pick]) begin
          pick = j;
        end else if (fit_mode == FIT_WORST && blk_free[j] > blk_free[pick]) begin
          pick = j;
        end
      end
    end
    if (!found) begin
      res.status = ST_NOT_ALLOC;
      return res;
    end
    blk_free[pick] = blk_free[pick] - want_size;
    res.status = ST_ALLOCATED;
    res.chosen_block = pick[3:0];
    res.size_left = blk_free[pick];
    return res;
  endfunction

  // Track register writes, predict on each accepted input word, check each result word.
  always @(posedge clk) begin
    grant_word_t got;
    grant_word_t want;
    if (rst) begin
      foreach (blk_free[i]) blk_free[i] = '0;
      fit_mode = FIT_FIRST;
      blk_count = 5'd16;
      awaited_grants.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_POLICY) fit_mode = cfg_data[1:0];
        else blk_count = cfg_data;
      end
      if (req.valid && req.ready) begin
        awaited_grants.push_back(next_grant(req.operation, req.block_index, req.size_value));
      end
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.chosen_block = rsp.chosen_block;
        got.size_left = rsp.size_left;
        if (awaited_grants.size() == 0) begin
          $error("result word arrived with none awaited: status %0d block %0d left %0d",
                 got.status, got.chosen_block, got.size_left);
          fail_count++;
        end else begin
          want = awaited_grants.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.chosen_block !== want.chosen_block) begin
            $error("chosen_block mismatch: expected %0d, got %0d",
                   want.chosen_block, got.chosen_block);
            fail_count++;
          end
          if (got.size_left !== want.size_left) begin
            $error("size_left mismatch: expected %0d, got %0d", want.size_left, got.size_left);
            fail_count++;
          end
        end
      end
    end
    open_words = awaited_grants.size();
  end

endmodule

/* test/tb_fit_policy_block_allocator.sv */
// Testbench top: clock, reset, stimulus and verdict for the fit-policy block allocator.
module tb_fit_policy_block_allocator
  import fpba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The spare policy code, which the block treats as first fit.
  localparam logic [1:0] FIT_SPARE = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;
  int         fail_count;
  int         open_words;
  bit         idle_on;

  fpba_req_if req_ch ();
  fpba_rsp_if rsp_ch ();

  fit_policy_block_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fpba_grant_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_words (open_words)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: stalls in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Presents one input word, possibly after a short gap, and waits until it is taken.
  task automatic send_word(input logic op, input logic [3:0] idx, input logic [15:0] sz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.block_index <= idx;
    req_ch.size_value <= sz;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every awaited result word has come back.
  task automatic drain_words();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (open_words != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sets both registers while the block is idle.
  task automatic set_policy(input logic [1:0] policy, input logic [4:0] count);
    drain_words();
    write_reg(CFG_FIT_POLICY, {3'b000, policy});
    write_reg(CFG_BLOCK_COUNT, count);
  endtask

  // Stimulus.
  initial begin
    logic [15:0] sz;
    logic        op;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FIT_POLICY;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_LOAD;
    req_ch.block_index = '0;
    req_ch.size_value = '0;
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table after reset: a zero request fits block 0, anything else fails.
    send_word(OP_ALLOC, 4'd9, 16'd0);
    send_word(OP_ALLOC, 4'd0, 16'd1);
    // Load the extremes and a pair of equal sizes.
    send_word(OP_LOAD, 4'd0, 16'hFFFF);
    send_word(OP_LOAD, 4'd15, 16'h8000);
    send_word(OP_LOAD, 4'd5, 16'd100);
    send_word(OP_LOAD, 4'd6, 16'd100);
    send_word(OP_LOAD, 4'd10, 16'd40);
    // First fit, including a request that nothing can hold.
    send_word(OP_ALLOC, 4'hF, 16'd30);
    send_word(OP_ALLOC, 4'd0, 16'hFFFF);
    send_word(OP_ALLOC, 4'd0, 16'h8000);
    // Best fit, with a tie and a zero request.
    set_policy(FIT_BEST, 5'd16);
    send_word(OP_ALLOC, 4'd3, 16'd30);
    send_word(OP_ALLOC, 4'd3, 16'd100);
    send_word(OP_ALLOC, 4'd7, 16'd0);
    // Worst fit, with a tie between two equal largest blocks.
    set_policy(FIT_WORST, 5'd16);
    send_word(OP_ALLOC, 4'd0, 16'd1);
    send_word(OP_LOAD, 4'd3, 16'h7FFF);
    send_word(OP_ALLOC, 4'd0, 16'h7FFF);
    // The spare policy code with a single block taking part.
    set_policy(FIT_SPARE, 5'd1);
    send_word(OP_ALLOC, 4'd0, 16'd1);
    send_word(OP_ALLOC, 4'd0, 16'd0);
    // No block taking part at all.
    set_policy(FIT_FIRST, 5'd0);
    send_word(OP_ALLOC, 4'd0, 16'd0);
    // A count beyond the table saturates to the full table.
    set_policy(FIT_WORST, 5'd31);
    send_word(OP_ALLOC, 4'd0, 16'd16);
    send_word(OP_ALLOC, 4'd0, 16'd16);

    // Random phases: loads keep the table filled so that allocations mostly succeed.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        1:       set_policy(phase[1:0], 5'd1);
        2:       set_policy(phase[1:0], 5'd31);
        5:       set_policy(phase[1:0], 5'd16);
        default: set_policy(phase[1:0], 5'($urandom_range(1, 16)));
      endcase
      idle_on = (phase < 7) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 148; n++) begin
        op = ($urandom_range(0, 9) < 4) ? OP_LOAD : OP_ALLOC;
        if (op == OP_LOAD) begin
          case ($urandom_range(0, 3))
            0:       sz = 16'($urandom_range(0, 65535));
            1:       sz = 16'd1 << $urandom_range(0, 15);
            2:       sz = 16'($urandom_range(0, 255));
            default: sz = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
          endcase
        end else begin
          sz = 16'($urandom_range(0, 65535) >> $urandom_range(0, 16));
        end
        send_word(op, 4'($urandom_range(0, 15)), sz);
      end
    end

    // Let every result word come back, then allow for the longest search.
    drain_words();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("fit_policy_block_allocator test passed");
    end else begin
      $display("fit_policy_block_allocator test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("fit_policy_block_allocator test failed");
    $finish;
  end

endmodule

/* sim.f */
design/fpba_pkg.sv
design/fpba_if.sv
design/fpba_cell.sv
design/fit_policy_block_allocator.sv
test/fpba_grant_checker.sv
test/tb_fit_policy_block_allocator.sv
